// ===== sv/rpip_pkg.sv =====
// Shared types, constants and helper functions for the radix-prefixed integer parser.
package rpip_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int QDEPTH      = 4;

    localparam logic [7:0] BIN_PFX_RST = 8'd98;
    localparam logic [7:0] OCT_PFX_RST = 8'd111;
    localparam logic [7:0] DEC_PFX_RST = 8'd100;
    localparam logic [7:0] HEX_PFX_RST = 8'd104;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD_RADIX = 2'd2;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd3;

    // radix select codes
    localparam logic [1:0] SEL_DEC = 2'd0;
    localparam logic [1:0] SEL_BIN = 2'd1;
    localparam logic [1:0] SEL_OCT = 2'd2;
    localparam logic [1:0] SEL_HEX = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BIN = 2'd0;
    localparam logic [1:0] CFG_OCT = 2'd1;
    localparam logic [1:0] CFG_DEC = 2'd2;
    localparam logic [1:0] CFG_HEX = 2'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status_code;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FOLD
    } t_op;

    // command from the classifier to the accumulator
    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic [1:0] radix_sel;
        logic       emit;
        logic [1:0] status;
    } t_cmd;

    // hex digit value in either case, 16 when the byte is no digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= CH_0 && c <= CH_9) begin
            d = 5'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = 5'(c - CH_LA) + 5'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = 5'(c - CH_UA) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_of(input logic [1:0] sel);
        logic [4:0] r;
        case (sel)
            SEL_BIN: r = 5'd2;
            SEL_OCT: r = 5'd8;
            SEL_HEX: r = 5'd16;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/rpip_front.sv =====
// Classifier: holds prefix registers and per-string radix, length and error state.
module rpip_front import rpip_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0]    r_bin_pfx, r_oct_pfx, r_dec_pfx, r_hex_pfx;
    logic [CW-1:0] r_seen, n_seen;
    logic [1:0]    r_sel, n_sel;
    logic [1:0]    r_err, n_err;
    logic          accept;
    logic [4:0]    dig;
    t_cmd          cmd;

    assign accept = i_in_valid && !i_q_full;

    always_comb begin
        n_seen = r_seen;
        n_sel  = r_sel;
        n_err  = r_err;
        dig    = digit_value(i_in_item.character);
        cmd    = '{op: OP_HOLD, digit: dig[3:0], radix_sel: r_sel, emit: 1'b0,
                   status: ST_OK};
        if (!i_in_item.empty_string) begin
            if (r_err == ST_OK && r_seen < CW'(MAX_LEN)) begin
                if (r_seen == '0) begin
                    n_seen = CW'(1);
                    // prefix registers win over the decimal-digit test
                    if (i_in_item.character == r_bin_pfx) begin
                        n_sel = SEL_BIN;
                    end else if (i_in_item.character == r_oct_pfx) begin
                        n_sel = SEL_OCT;
                    end else if (i_in_item.character == r_dec_pfx) begin
                        n_sel = SEL_DEC;
                    end else if (i_in_item.character == r_hex_pfx) begin
                        n_sel = SEL_HEX;
                    end else if (i_in_item.character inside {[CH_0:CH_9]}) begin
                        n_sel  = SEL_DEC;
                        cmd.op = OP_LOAD;
                    end else begin
                        n_err = ST_BAD_RADIX;
                    end
                end else begin
                    n_seen = r_seen + CW'(1);
                    if (dig >= radix_of(r_sel)) begin
                        n_err = ST_BAD_CHAR;
                    end else begin
                        cmd.op = OP_FOLD;
                    end
                end
            end
        end
        cmd.radix_sel = n_sel;
        if (i_in_item.empty_string || i_in_item.last_char) begin
            cmd.emit   = 1'b1;
            cmd.status = (n_seen == '0) ? ST_TOO_SHORT : n_err;
            n_seen     = '0;
            n_sel      = SEL_DEC;
            n_err      = ST_OK;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.emit || cmd.op != OP_HOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_pfx <= BIN_PFX_RST;
            r_oct_pfx <= OCT_PFX_RST;
            r_dec_pfx <= DEC_PFX_RST;
            r_hex_pfx <= HEX_PFX_RST;
            r_seen    <= '0;
            r_sel     <= SEL_DEC;
            r_err     <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BIN: r_bin_pfx <= i_cfg_wdata;
                    CFG_OCT: r_oct_pfx <= i_cfg_wdata;
                    CFG_DEC: r_dec_pfx <= i_cfg_wdata;
                    CFG_HEX: r_hex_pfx <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_seen <= n_seen;
                r_sel  <= n_sel;
                r_err  <= n_err;
            end
        end
    end

endmodule

// ===== sv/rpip_queue.sv =====
// Small command FIFO between the classifier and the accumulator.
module rpip_queue import rpip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int AW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    t_cmd          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(QDEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(QDEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/rpip_back.sv =====
// Accumulator: Horner fold by shift-add and the registered result stage.
module rpip_back import rpip_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [63:0] r_acc, acc_next, acc_mul;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item;
    logic        out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    // only a command that emits needs the result stage
    assign o_pop    = i_q_valid && (!i_q_cmd.emit || out_free);

    always_comb begin
        case (i_q_cmd.radix_sel)
            SEL_BIN: acc_mul = {r_acc[62:0], 1'b0};
            SEL_OCT: acc_mul = {r_acc[60:0], 3'b0};
            SEL_HEX: acc_mul = {r_acc[59:0], 4'b0};
            default: acc_mul = {r_acc[60:0], 3'b0} + {r_acc[62:0], 1'b0};
        endcase
        case (i_q_cmd.op)
            OP_LOAD: acc_next = {60'd0, i_q_cmd.digit};
            OP_FOLD: acc_next = acc_mul + {60'd0, i_q_cmd.digit};
            default: acc_next = r_acc;
        endcase
    end

    // result stage empties when taken and refills on an emitting pop
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_pop && i_q_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.emit) begin
            r_out_item.value       <= (i_q_cmd.status == ST_OK) ? acc_next : 64'd0;
            r_out_item.status_code <= i_q_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_q_cmd.emit) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_next;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/radix_prefixed_integer_parser_unit.sv =====
// Top level of the radix-prefixed integer parser.
// Takes one string character per cycle and returns a 64-bit value with a status when a
// string ends (last_char, or an empty_string item). The classifier decides radix, digit
// validity and errors in the cycle a character is taken and posts a command to a
// 4-entry queue; the accumulator folds one digit per cycle unless the output stalls, by
// shift-add (x2, x8, x16, or x8+x2), and loads the result register. Input stalls only
// while the queue is full, which happens only when the output side stalls. The user
// must write the prefix registers through the plain config port (0 binary, 1 octal, 2
// decimal, 3 hex) only while the block is idle; the block itself does not enforce it.
module radix_prefixed_integer_parser_unit import rpip_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    assign o_in_stall = q_full;

    rpip_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (f_cmd)
    );

    rpip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    rpip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/rpip_checker.sv =====
// Port-level checks for the parser, bound to the top level.
module rpip_checker import rpip_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // output transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed under stall");

    // any error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status_code != ST_OK |-> o_out_item.value == 64'd0)
        else $error("nonzero value with error status");

    // reset empties the queue and the result stage
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    // input can only back up while the output side is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid) && $past(i_out_stall))
        else $error("input stall without output back-pressure");

endmodule

bind radix_prefixed_integer_parser_unit rpip_checker u_rpip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
